// ===== src/linear_table_interpolator_unit_defines.svh =====
// assertion macros for the linear table interpolator
// used by linear_table_interpolator_unit; expects clk_i and rst_ni in scope
`ifndef LINEAR_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH
`define LINEAR_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define LTI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lti assertion failed");

// next-cycle implication, off during reset
`define LTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lti assertion failed");

`endif

// ===== src/lti_pkg.sv =====
// shared constants, types and sequencer states of the linear table interpolator
// no dependencies; used by the channel interfaces and the top level
package lti_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 7;
  localparam int PIDX_W      = 6;
  localparam int VAL_W       = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 2;
  localparam int DIV_STEPS   = VAL_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  PCOUNT_RESET        = CNT_W'(2);
  localparam logic [ADDR_W-1:0] REG_POINT_COUNT_ADR = ADDR_W'(0);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHKN,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_RESP
  } lti_state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    oor;
  } lti_result_t;

endpackage

// ===== src/lti_req_if.sv =====
// request channel of the linear table interpolator: valid/ready plus payload
// depends on lti_pkg
interface lti_req_if;
  import lti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [PIDX_W-1:0]        point_index;
  logic signed [VAL_W-1:0]  x_value;
  logic signed [VAL_W-1:0]  y_value;
  logic signed [VAL_W-1:0]  target_x;

  modport source (
    output valid, req_type, point_index, x_value, y_value, target_x,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_index, x_value, y_value, target_x,
    output ready
  );
endinterface

// ===== src/lti_rsp_if.sv =====
// result channel of the linear table interpolator: valid/ready plus payload
// depends on lti_pkg
interface lti_rsp_if;
  import lti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  result_value;
  logic                     out_of_range;

  modport source (
    output valid, result_value, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, result_value, out_of_range,
    output ready
  );
endinterface

// ===== src/linear_table_interpolator_unit.sv =====
// linear_table_interpolator_unit: a load request is taken in idle and is followed at once.
// a query for n points runs through two span checks, up to n-1 scan
// reads, one 32x32 multiply, a 32-step restoring divide, a sum, a result handoff.
// the breakpoint memory is single-port and the divider forms one quotient bit per cycle.
// reset (async, active low) returns to idle, empties the output, point_count to 2.
// depends on lti_pkg, lti_req_if, lti_rsp_if and the defines header
`include "linear_table_interpolator_unit_defines.svh"

module linear_table_interpolator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lti_req_if.sink                      req_i,
  lti_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lti_pkg::ADDR_W-1:0]   paddr,
  input  logic [lti_pkg::DATA_W-1:0]   pwdata,
  output logic [lti_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lti_pkg::*;

  lti_state_e state_q, state_d;

  logic [CNT_W-1:0]        pcount_q;
  logic [CNT_W-1:0]        n_sat;
  logic                    req_acc;
  logic                    cfg_wr;

  // breakpoint memory, one read port with registered data
  logic signed [VAL_W-1:0] x_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] y_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] rd_x_q, rd_y_q;
  logic                    mem_we;

  // work registers
  logic signed [VAL_W-1:0] t_q, t_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic signed [VAL_W-1:0] xa_q, xa_d;
  logic signed [VAL_W-1:0] ya_q, ya_d;
  logic [VAL_W-1:0]        dx_q, dx_d;
  logic [VAL_W-1:0]        mag_q, mag_d;
  logic [VAL_W-1:0]        off_q, off_d;
  logic                    neg_q, neg_d;
  logic [VAL_W-1:0]        rem_q, rem_d;
  logic [VAL_W-1:0]        quo_q, quo_d;
  logic [DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  lti_result_t             rslt_q, rslt_d;
  lti_result_t             out_q;
  logic                    ovalid_q, ovalid_d;
  logic                    load_out;

  // shared datapath terms
  logic                    t_ge_xa, t_le_rd;
  logic signed [VAL_W:0]   dx_w, dy_w, dy_abs;
  logic [2*VAL_W-1:0]      prod;
  logic [VAL_W:0]          div_r;
  logic                    div_ge;
  logic signed [VAL_W+1:0] sum_w;
  logic signed [VAL_W-1:0] sum_sat;

  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign mem_we = req_acc && (req_i.req_type == REQ_LOAD)
                  && (32'(req_i.point_index) < 32'(MAX_ENTRIES));

  assign n_sat = (32'(pcount_q) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : pcount_q;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_POINT_COUNT_ADR);
  assign prdata = (paddr == REG_POINT_COUNT_ADR) ? DATA_W'(pcount_q) : '0;

  assign t_ge_xa = (t_q >= xa_q);
  assign t_le_rd = (t_q <= rd_x_q);
  assign dx_w    = {rd_x_q[VAL_W-1], rd_x_q} - {xa_q[VAL_W-1], xa_q};
  assign dy_w    = {rd_y_q[VAL_W-1], rd_y_q} - {ya_q[VAL_W-1], ya_q};
  assign dy_abs  = dy_w[VAL_W] ? -dy_w : dy_w;
  assign prod    = mag_q * off_q;
  assign div_r   = {rem_q, quo_q[VAL_W-1]};
  assign div_ge  = (div_r >= {1'b0, dx_q});

  always_comb begin
    sum_w = neg_q ? ({{2{ya_q[VAL_W-1]}}, ya_q} - {2'b00, quo_q})
                  : ({{2{ya_q[VAL_W-1]}}, ya_q} + {2'b00, quo_q});
    // saturate when the top three bits disagree
    if (sum_w[VAL_W+1:VAL_W-1] == 3'b000 || sum_w[VAL_W+1:VAL_W-1] == 3'b111) begin
      sum_sat = sum_w[VAL_W-1:0];
    end else if (sum_w[VAL_W+1]) begin
      sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    n_d       = n_q;
    idx_d     = idx_q;
    xa_d      = xa_q;
    ya_d      = ya_q;
    dx_d      = dx_q;
    mag_d     = mag_q;
    off_d     = off_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    div_cnt_d = div_cnt_q;
    rslt_d    = rslt_q;
    rd_addr   = IDX_W'(idx_q);
    load_out  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (req_acc && req_i.req_type == REQ_QUERY) begin
          t_d   = req_i.target_x;
          n_d   = n_sat;
          idx_d = '0;
          if (n_sat == '0) begin
            rslt_d  = '{value: '0, oor: 1'b1};
            state_d = ST_RESP;
          end else begin
            state_d = ST_CHK0;
          end
        end
      end
      ST_CHK0: begin
        if (t_q < rd_x_q) begin
          rslt_d  = '{value: '0, oor: 1'b1};
          state_d = ST_RESP;
        end else begin
          xa_d    = rd_x_q;
          ya_d    = rd_y_q;
          rd_addr = IDX_W'(n_q - CNT_W'(1));
          state_d = ST_CHKN;
        end
      end
      ST_CHKN: begin
        if (t_q > rd_x_q) begin
          rslt_d  = '{value: '0, oor: 1'b1};
          state_d = ST_RESP;
        end else if (n_q == CNT_W'(1)) begin
          // single point, target sits on it
          rslt_d  = '{value: '0, oor: 1'b0};
          state_d = ST_RESP;
        end else begin
          idx_d   = CNT_W'(1);
          rd_addr = IDX_W'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (t_ge_xa && t_le_rd) begin
          if (!dx_w[VAL_W] && dx_w != '0) begin
            dx_d    = dx_w[VAL_W-1:0];
            mag_d   = dy_abs[VAL_W-1:0];
            neg_d   = dy_w[VAL_W];
            off_d   = VAL_W'(t_q - xa_q);
            state_d = ST_MUL;
          end else begin
            // zero-width interval answers the left ordinate
            rslt_d  = '{value: ya_q, oor: 1'b0};
            state_d = ST_RESP;
          end
        end else begin
          xa_d = rd_x_q;
          ya_d = rd_y_q;
          if (idx_q == n_q - CNT_W'(1)) begin
            // unsorted table, no interval holds the target
            rslt_d  = '{value: '0, oor: 1'b0};
            state_d = ST_RESP;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            rd_addr = IDX_W'(idx_q + CNT_W'(1));
          end
        end
      end
      ST_MUL: begin
        rem_d     = prod[2*VAL_W-1:VAL_W];
        quo_d     = prod[VAL_W-1:0];
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        // quotient fits 32 bits since off <= dx, so the high half is below dx
        rem_d     = div_ge ? VAL_W'(div_r - {1'b0, dx_q}) : div_r[VAL_W-1:0];
        quo_d     = {quo_q[VAL_W-2:0], div_ge};
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        rslt_d  = '{value: sum_sat, oor: 1'b0};
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!ovalid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ovalid_d = load_out || (ovalid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      pcount_q <= PCOUNT_RESET;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr) begin
        pcount_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    xa_q      <= xa_d;
    ya_q      <= ya_d;
    dx_q      <= dx_d;
    mag_q     <= mag_d;
    off_q     <= off_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_cnt_q <= div_cnt_d;
    rslt_q    <= rslt_d;
    if (load_out) begin
      out_q <= rslt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      x_mem[IDX_W'(req_i.point_index)] <= req_i.x_value;
      y_mem[IDX_W'(req_i.point_index)] <= req_i.y_value;
    end
    rd_x_q <= x_mem[rd_addr];
    rd_y_q <= y_mem[rd_addr];
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.result_value = out_q.value;
  assign rsp_o.out_of_range = out_q.oor;

  `LTI_ASSERT_NEXT(a_query_leaves_idle, req_acc && req_i.req_type == REQ_QUERY, state_q != ST_IDLE)
  `LTI_ASSERT_NEXT(a_load_stays_idle, req_acc && req_i.req_type == REQ_LOAD, state_q == ST_IDLE)
  `LTI_ASSERT_IMPL(a_quotient_bounded, state_q == ST_SUM, quo_q <= mag_q)
  `LTI_ASSERT_IMPL(a_oor_gives_zero, rsp_o.valid && rsp_o.out_of_range, rsp_o.result_value == '0)

endmodule
